// ----- design/assert_macros.svh -----
// Assertion macros shared by the rate limiter RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/pmrl_pkg.sv -----
// Types and constants of the per-client rate limiter.
// No dependencies; used by pmrl_cell and per_mac_rate_limiter.
`timescale 1ns / 1ps
`default_nettype none

package pmrl_pkg;

  localparam int MacW = 48;
  localparam int TimeW = 32;
  localparam int HitW = 8;
  localparam int LimitW = 8;
  localparam int WindowW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [HitW-1:0] HitMax = 8'hFF;

  localparam logic [CfgIdxW-1:0] RegRequestLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindowSeconds = 2'd1;

  localparam logic [LimitW-1:0] LimitReset = 8'd5;
  localparam logic [WindowW-1:0] WindowReset = 16'd1;

  typedef enum logic [1:0] {
    VERDICT_KNOWN_OK = 2'd0,
    VERDICT_NEW_OK   = 2'd1,
    VERDICT_OVER     = 2'd2,
    VERDICT_FULL     = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [MacW-1:0]  mac;
    logic [TimeW-1:0] now;
  } req_t;

  typedef struct packed {
    logic     valid;
    logic     found;
    verdict_t verdict;
    req_t     req;
  } tok_t;

  typedef struct packed {
    logic [LimitW-1:0]  limit;
    logic [WindowW-1:0] window;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/pmrl_cell.sv -----
// One table entry of the rate limiter: address, window start and hit count.
// Passes the lookup token to its neighbor each cycle. Depends on pmrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmrl_cell (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire pmrl_pkg::cfg_t cfg,
  input  wire logic         en,
  input  wire logic         ins,
  input  wire pmrl_pkg::req_t ins_req,
  input  wire pmrl_pkg::tok_t tok_in,
  output pmrl_pkg::tok_t    tok_out
);

  logic [pmrl_pkg::MacW-1:0]  addr;
  logic [pmrl_pkg::TimeW-1:0] start;
  logic [pmrl_pkg::HitW-1:0]  hits;

  logic [pmrl_pkg::TimeW-1:0] elapsed;
  logic                       restart;
  logic [pmrl_pkg::HitW-1:0]  base;
  logic [pmrl_pkg::HitW-1:0]  hits_next;
  logic                       match;
  pmrl_pkg::tok_t             tok_next;

  always_comb begin
    elapsed = tok_in.req.now - start;
    restart = elapsed >= {{(pmrl_pkg::TimeW-pmrl_pkg::WindowW){1'b0}}, cfg.window};
    base = restart ? '0 : hits;
    hits_next = (base == pmrl_pkg::HitMax) ? base : base + 1'b1;
    match = tok_in.valid && !tok_in.found && en && (addr == tok_in.req.mac);
    tok_next = tok_in;
    if (match) begin
      tok_next.found = 1'b1;
      tok_next.verdict = (hits_next > cfg.limit) ? pmrl_pkg::VERDICT_OVER
                                                 : pmrl_pkg::VERDICT_KNOWN_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      addr <= ins_req.mac;
      start <= ins_req.now;
      hits <= {{(pmrl_pkg::HitW-1){1'b0}}, 1'b1};
    end else if (match) begin
      hits <= hits_next;
      if (restart) begin
        start <= tok_in.req.now;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/per_mac_rate_limiter.sv -----
// Top level of the per-client fixed-window rate limiter: control, chain of
// entry cells, configuration and result register. Depends on pmrl_pkg,
// pmrl_cell and assert_macros.svh.
//
//   channel | dir | payload
//   s_axis  | in  | tdata[47:0] client_mac, tdata[79:48] now_seconds
//   m_axis  | out | tdata[0] allowed, tdata[2:1] verdict_code
//   cfg     | in  | cfg_index register, cfg_data value
//
// A request is registered at accept, walks the cell chain and is captured at the
// tail; the finish step loads the output register, then idle takes the next one.
// One request is in flight at a time; a result may wait in the output register.
// Synchronous reset empties the table, loads the defaults and drops both readies.
// A stalled output holds the finish step until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module per_mac_rate_limiter #(
  parameter int TABLE_ENTRIES = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [79:0]                   s_axis_tdata,  // client_mac, now_seconds
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // allowed, verdict_code, zero pad
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pmrl_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pmrl_pkg::CfgDataW-1:0] cfg_data
);

  localparam int UsedW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [UsedW-1:0] Full = UsedW'(TABLE_ENTRIES);

  pmrl_pkg::state_t state;
  pmrl_pkg::state_t state_next;
  pmrl_pkg::cfg_t   cfg;
  pmrl_pkg::req_t   req;
  logic [UsedW-1:0] used;

  logic               res_found;
  pmrl_pkg::verdict_t res_verdict;

  logic               out_valid;
  logic               out_allowed;
  pmrl_pkg::verdict_t out_verdict;

  logic in_ready;
  logic launch;
  logic finish_go;
  logic ins_go;
  logic out_free;
  logic accept;

  pmrl_pkg::tok_t tok [0:TABLE_ENTRIES];

  assign cfg_ready = !rst;
  assign s_axis_tready = in_ready && !rst;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign ins_go = finish_go && !res_found && (used < Full);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'b0, out_verdict, out_allowed};

  always_comb begin
    state_next = state;
    case (state)
      pmrl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_next = pmrl_pkg::ST_LAUNCH;
      end
      pmrl_pkg::ST_LAUNCH: state_next = pmrl_pkg::ST_SCAN;
      pmrl_pkg::ST_SCAN: begin
        if (tok[TABLE_ENTRIES].valid) state_next = pmrl_pkg::ST_FINISH;
      end
      pmrl_pkg::ST_FINISH: begin
        if (out_free) state_next = pmrl_pkg::ST_IDLE;
      end
      default: state_next = pmrl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    launch = 1'b0;
    finish_go = 1'b0;
    case (state)
      pmrl_pkg::ST_IDLE:   in_ready = 1'b1;
      pmrl_pkg::ST_LAUNCH: launch = 1'b1;
      pmrl_pkg::ST_SCAN:   ;
      pmrl_pkg::ST_FINISH: finish_go = out_free;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit <= pmrl_pkg::LimitReset;
      cfg.window <= pmrl_pkg::WindowReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmrl_pkg::RegRequestLimit:  cfg.limit <= cfg_data[pmrl_pkg::LimitW-1:0];
        pmrl_pkg::RegWindowSeconds: cfg.window <= cfg_data;
        default:                    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.mac <= s_axis_tdata[47:0];
      req.now <= s_axis_tdata[79:48];
    end
    if (tok[TABLE_ENTRIES].valid) begin
      res_found <= tok[TABLE_ENTRIES].found;
      res_verdict <= tok[TABLE_ENTRIES].verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ins_go) begin
      used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      if (res_found) begin
        out_verdict <= res_verdict;
        out_allowed <= (res_verdict == pmrl_pkg::VERDICT_KNOWN_OK);
      end else if (used < Full) begin
        out_verdict <= pmrl_pkg::VERDICT_NEW_OK;
        out_allowed <= 1'b1;
      end else begin
        out_verdict <= pmrl_pkg::VERDICT_FULL;
        out_allowed <= 1'b0;
      end
    end
  end

  always_comb begin
    tok[0].valid = launch;
    tok[0].found = 1'b0;
    tok[0].verdict = pmrl_pkg::VERDICT_KNOWN_OK;
    tok[0].req = req;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    pmrl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cfg     (cfg),
      .en      (used > UsedW'(k)),
      .ins     (ins_go && (used == UsedW'(k))),
      .ins_req (req),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  `ASSERT_NEXT(a_accept_launch, clk, rst, accept, state == pmrl_pkg::ST_LAUNCH)
  `ASSERT_IMPL(a_tail_in_scan, clk, rst, tok[TABLE_ENTRIES].valid, state == pmrl_pkg::ST_SCAN)
  `ASSERT_NEXT(a_used_stable, clk, rst, !ins_go, $stable(used))
  `ASSERT_IMPL(a_allowed_code, clk, rst, m_axis_tvalid,
    out_allowed == (out_verdict == pmrl_pkg::VERDICT_KNOWN_OK ||
                    out_verdict == pmrl_pkg::VERDICT_NEW_OK))

endmodule

`default_nettype wire

// ----- tb/sv/per_mac_rate_limiter_test.sv -----
// Self-checking testbench for per_mac_rate_limiter: directed and random request
// streams with random stalls on both stream sides, checked against a predictor.
// Depends on pmrl_pkg and the per_mac_rate_limiter RTL.
`timescale 1ns / 1ps

module per_mac_rate_limiter_test;
  import pmrl_pkg::*;

  localparam int TABLE_ENTRIES = 20;
  localparam logic [CfgIdxW-1:0] RegUnused2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnused3 = 2'd3;

  typedef struct packed {
    logic     allowed;
    verdict_t verdict;
  } verdict_rec_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [79:0]         s_axis_tdata = '0;  // client_mac, now_seconds
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;       // allowed, verdict_code, zero pad
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state
  logic [MacW-1:0]    mac_tab[TABLE_ENTRIES];
  logic [TimeW-1:0]   start_tab[TABLE_ENTRIES];
  logic [HitW-1:0]    hit_tab[TABLE_ENTRIES];
  int                 tracked_count = 0;
  logic [LimitW-1:0]  limit_reg = LimitReset;
  logic [WindowW-1:0] window_reg = WindowReset;

  verdict_rec_t       expected_verdicts[$];
  logic [MacW-1:0]    client_pool[TABLE_ENTRIES];
  logic [TimeW-1:0]   cur_time = '0;
  int                 mismatches = 0;
  int                 send_idle_pct = 29;
  int                 recv_idle_pct = 71;
  int                 hold_left = 0;
  int                 hold_req = 0;
  int                 hold_seen = 0;

  per_mac_rate_limiter #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    verdict_rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected, actual tdata=%h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.allowed) begin
          $display("%0t: allowed mismatch, expected %0d actual %0d",
                   $time, want.allowed, m_axis_tdata[0]);
          mismatches++;
        end
        if (m_axis_tdata[2:1] !== want.verdict) begin
          $display("%0t: verdict_code mismatch, expected %0d actual %0d",
                   $time, want.verdict, m_axis_tdata[2:1]);
          mismatches++;
        end
      end
    end
  end

  function automatic verdict_rec_t rate_verdict(input logic [MacW-1:0] mac,
                                                input logic [TimeW-1:0] now);
    verdict_rec_t     rec;
    logic [TimeW-1:0] elapsed;
    logic [HitW-1:0]  hits;
    for (int k = 0; k < tracked_count; k++) begin
      if (mac_tab[k] == mac) begin
        elapsed = now - start_tab[k];
        if (elapsed >= {16'd0, window_reg}) begin
          hit_tab[k] = '0;
          start_tab[k] = now;
        end
        hits = hit_tab[k];
        if (hits != HitMax) hits++;
        hit_tab[k] = hits;
        if (hits > limit_reg) rec = '{allowed: 1'b0, verdict: VERDICT_OVER};
        else rec = '{allowed: 1'b1, verdict: VERDICT_KNOWN_OK};
        return rec;
      end
    end
    if (tracked_count < TABLE_ENTRIES) begin
      mac_tab[tracked_count] = mac;
      start_tab[tracked_count] = now;
      hit_tab[tracked_count] = 8'd1;
      tracked_count++;
      rec = '{allowed: 1'b1, verdict: VERDICT_NEW_OK};
    end else begin
      rec = '{allowed: 1'b0, verdict: VERDICT_FULL};
    end
    return rec;
  endfunction

  task automatic send_request(input logic [MacW-1:0] mac, input logic [TimeW-1:0] now);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {now, mac};
    do @(posedge clk); while (!s_axis_tready);
    expected_verdicts.push_back(rate_verdict(mac, now));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegRequestLimit) limit_reg = data[LimitW-1:0];
    else if (idx == RegWindowSeconds) window_reg = data;
  endtask

  task automatic configure(input logic [LimitW-1:0] limit, input logic [WindowW-1:0] window);
    wait_for_results();
    write_reg(RegRequestLimit, {8'($urandom), limit});
    write_reg(RegWindowSeconds, window);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MacW-1:0] stranger_mac();
    logic [MacW-1:0] mac;
    logic            clash;
    do begin
      mac = {16'($urandom), 32'($urandom)};
      clash = 1'b0;
      foreach (client_pool[k]) if (client_pool[k] == mac) clash = 1'b1;
    end while (clash);
    return mac;
  endfunction

  function automatic logic [TimeW-1:0] advance_time();
    int r;
    r = $urandom_range(99);
    if (r < 60) ;
    else if (r < 85) cur_time += $urandom_range(1, 4);
    else if (r < 92) cur_time += $urandom_range(5, 100);
    else if (r < 96) cur_time -= $urandom_range(1, 50);
    else cur_time = $urandom;
    return cur_time;
  endfunction

  task automatic test_new_clients();
    send_request(client_pool[0], 32'h0000_0000);
    send_request(client_pool[1], 32'hFFFF_FFFF);
    send_request(client_pool[0], 32'h0000_0000);
    send_request(client_pool[1], 32'h0000_0000);
  endtask

  task automatic test_request_limits();
    configure(8'd1, 16'hFFFF);
    send_request(client_pool[4], 32'd100);
    send_request(client_pool[4], 32'd100);
    configure(8'd254, 16'hFFFF);
    send_request(client_pool[4], 32'd100);
    configure(8'd0, 16'hFFFF);
    send_request(client_pool[4], 32'd100);
    send_request(client_pool[5], 32'd100);
    configure(8'd255, 16'hFFFF);
    send_request(client_pool[4], 32'd100);
  endtask

  task automatic test_window_rules();
    configure(8'd5, 16'd10);
    send_request(client_pool[2], 32'd5000);
    send_request(client_pool[2], 32'd5009);
    send_request(client_pool[2], 32'd5010);
    configure(8'd5, 16'd0);
    repeat (3) send_request(client_pool[2], 32'd5010);
    configure(8'd5, 16'd100);
    send_request(client_pool[3], 32'hFFFF_FFFF);
    send_request(client_pool[3], 32'h0000_0000);
    send_request(client_pool[3], 32'hFFFF_FFF0);
  endtask

  task automatic test_register_index();
    wait_for_results();
    write_reg(RegRequestLimit, 16'd3);
    write_reg(RegUnused2, 16'hFFFF);
    write_reg(RegWindowSeconds, 16'd50);
    write_reg(RegUnused3, 16'h0000);
    cfg_valid <= 1'b0;
    repeat (4) send_request(client_pool[5], 32'd7000);
  endtask

  task automatic test_hit_saturation();
    configure(8'd254, 16'hFFFF);
    repeat (256) send_request(client_pool[3], 32'h4000_0000);
    configure(8'd255, 16'hFFFF);
    repeat (3) send_request(client_pool[3], 32'h4000_0000);
  endtask

  task automatic test_table_full();
    configure(8'd5, 16'd1);
    foreach (client_pool[k]) send_request(client_pool[k], 32'd9000);
    repeat (10) send_request(stranger_mac(), 32'($urandom));
  endtask

  task automatic test_backpressure();
    configure(8'd4, 16'd20);
    send_idle_pct = 0;
    @(posedge clk);
    hold_req++;
    repeat (12) send_request(client_pool[$urandom_range(TABLE_ENTRIES - 1)], cur_time);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count);
    logic [MacW-1:0] mac;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(3))
          0: configure(8'd1, 16'd1);
          1: configure(8'd254, 16'hFFFF);
          2: configure(8'($urandom_range(1, 8)), 16'($urandom_range(1, 16)));
          default: configure(8'($urandom_range(1, 254)), 16'($urandom_range(1, 65535)));
        endcase
      end
      if ($urandom_range(99) < 85) mac = client_pool[$urandom_range(TABLE_ENTRIES - 1)];
      else mac = stranger_mac();
      send_request(mac, advance_time());
    end
  endtask

  initial begin
    logic clash;
    client_pool[0] = '0;
    client_pool[1] = '1;
    for (int k = 2; k < TABLE_ENTRIES; k++) begin
      do begin
        client_pool[k] = {16'($urandom), 32'($urandom)};
        clash = (client_pool[k] == '0) || (client_pool[k] == '1);
        for (int j = 2; j < k; j++) if (client_pool[j] == client_pool[k]) clash = 1'b1;
      end while (clash);
    end
    foreach (mac_tab[k]) begin
      mac_tab[k] = '0;
      start_tab[k] = '0;
      hit_tab[k] = '0;
    end
    cur_time = $urandom;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 71;
    test_new_clients();
    test_request_limits();
    test_window_rules();
    test_register_index();
    test_hit_saturation();
    test_table_full();
    test_random_traffic(460);

    send_idle_pct = 71;
    recv_idle_pct = 29;
    test_random_traffic(460);

    recv_idle_pct = 0;
    test_backpressure();
    send_idle_pct = 0;
    test_random_traffic(460);

    wait_for_results();
    repeat (TABLE_ENTRIES + 10) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
